// ----- hw/rtl/flvp_pkg.sv -----
// Shared types and constants for the FLV tag stream parser.
// Holds the result record layout and the tag type and record kind codes.
// No dependencies.
package flvp_pkg;

  // Tag type byte values from the tag header.
  localparam logic [7:0] AUDIO_TAG  = 8'd8;
  localparam logic [7:0] VIDEO_TAG  = 8'd9;
  localparam logic [7:0] SCRIPT_TAG = 8'd18;

  // Record kind codes on the result stream.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_AUDIO  = 2'd1;
  localparam logic [1:0] KIND_VIDEO  = 2'd2;
  localparam logic [1:0] KIND_SCRIPT = 2'd3;

  // Widths of the stream payloads.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 120;
  localparam int OUT_USER_W = 2;

  // One result record.
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] tag_number;
    logic [7:0]  tag_type_code;
    logic [31:0] length_value;
    logic [23:0] time_stamp;
    logic [7:0]  file_flags;
    logic [3:0]  sound_format;
    logic [1:0]  rate_code;
    logic        sample_wide;
    logic        is_stereo;
    logic [3:0]  frame_kind;
    logic [3:0]  codec_id;
  } record_t;

endpackage

// ----- hw/rtl/flvp_core.sv -----
// Parse state machine of the FLV tag stream parser.
// Consumes one stream byte per accepted word and forms at most one record.
// Depends on flvp_pkg.
module flvp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              separate_av,
  output logic              res_valid,
  output flvp_pkg::record_t res
);
  import flvp_pkg::*;

  // Parse phase codes; unused codes behave as the previous-size phase.
  localparam logic [2:0] PH_HEADER      = 3'd0;
  localparam logic [2:0] PH_SKIP_OFFSET = 3'd1;
  localparam logic [2:0] PH_PREV_SIZE   = 3'd2;
  localparam logic [2:0] PH_TAG_HEADER  = 3'd3;
  localparam logic [2:0] PH_FIRST_DATA  = 3'd4;
  localparam logic [2:0] PH_SKIP_DATA   = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [31:0] byte_pos, byte_pos_next;
  logic [31:0] assembly_word, assembly_word_next;
  logic [31:0] tag_counter, tag_counter_next;
  logic [7:0]  current_type, current_type_next;
  logic [23:0] current_size, current_size_next;
  logic [23:0] current_time, current_time_next;
  logic [7:0]  header_flags_held, header_flags_held_next;

  logic [31:0] count_inc;
  logic [31:0] count_dec;
  logic [31:0] offset;
  logic [7:0]  eff_type;
  logic [1:0]  tag_kind;
  logic [1:0]  first_kind;
  logic [23:0] size_left;

  assign count_inc = byte_pos + 32'd1;
  assign count_dec = (byte_pos != 32'd0) ? (byte_pos - 32'd1) : 32'd0;
  assign offset    = {assembly_word[23:0], data_byte};
  assign size_left = current_size - 24'd1;

  // Classify the tag; without separate mode every tag counts as video.
  always_comb begin
    eff_type = separate_av ? current_type : VIDEO_TAG;
    case (eff_type)
      AUDIO_TAG:  tag_kind = KIND_AUDIO;
      VIDEO_TAG:  tag_kind = KIND_VIDEO;
      SCRIPT_TAG: tag_kind = KIND_SCRIPT;
      default:    tag_kind = KIND_HEADER;
    endcase
    first_kind = (assembly_word == {30'd0, KIND_AUDIO}) ? KIND_AUDIO : KIND_VIDEO;
  end

  // Next state and result record for the byte on the input.
  always_comb begin
    phase_next             = phase;
    byte_pos_next          = byte_pos;
    assembly_word_next     = assembly_word;
    tag_counter_next       = tag_counter;
    current_type_next      = current_type;
    current_size_next      = current_size;
    current_time_next      = current_time;
    header_flags_held_next = header_flags_held;
    res_valid              = 1'b0;
    res                    = '0;

    case (phase)
      PH_HEADER: begin
        if (byte_pos == 32'd4) header_flags_held_next = data_byte;
        if (byte_pos >= 32'd5) assembly_word_next = offset;
        byte_pos_next = count_inc;
        if (byte_pos >= 32'd8) begin
          res_valid        = 1'b1;
          res.record_kind  = KIND_HEADER;
          res.length_value = offset;
          res.file_flags   = header_flags_held;
          // A small offset means the first tag follows right away.
          if (offset > 32'd9) begin
            byte_pos_next = offset - 32'd9;
            phase_next    = PH_SKIP_OFFSET;
          end else begin
            byte_pos_next = 32'd0;
            phase_next    = PH_PREV_SIZE;
          end
        end
      end

      PH_SKIP_OFFSET, PH_SKIP_DATA: begin
        byte_pos_next = count_dec;
        if (count_dec == 32'd0) phase_next = PH_PREV_SIZE;
      end

      PH_TAG_HEADER: begin
        byte_pos_next = count_inc;
        if (byte_pos == 32'd0) begin
          current_type_next = data_byte;
        end else if (byte_pos <= 32'd3) begin
          assembly_word_next = (byte_pos == 32'd1) ? {24'd0, data_byte} : offset;
          if (byte_pos == 32'd3) current_size_next = assembly_word_next[23:0];
        end else if (byte_pos <= 32'd6) begin
          assembly_word_next = (byte_pos == 32'd4) ? {24'd0, data_byte} : offset;
          if (byte_pos == 32'd6) current_time_next = assembly_word_next[23:0];
        end
        // Last tag header byte: count the tag and decide what follows.
        if (byte_pos >= 32'd10) begin
          tag_counter_next = tag_counter + 32'd1;
          if ((tag_kind == KIND_AUDIO || tag_kind == KIND_VIDEO) &&
              current_size != 24'd0) begin
            assembly_word_next = {30'd0, tag_kind};
            phase_next         = PH_FIRST_DATA;
            byte_pos_next      = 32'd0;
          end else begin
            byte_pos_next = {8'd0, current_size};
            phase_next    = (current_size == 24'd0) ? PH_PREV_SIZE : PH_SKIP_DATA;
            if (tag_kind != KIND_HEADER) begin
              res_valid         = 1'b1;
              res.record_kind   = tag_kind;
              res.tag_number    = tag_counter;
              res.tag_type_code = current_type;
              res.length_value  = {8'd0, current_size};
              res.time_stamp    = current_time;
            end
          end
        end
      end

      PH_FIRST_DATA: begin
        res_valid         = 1'b1;
        res.record_kind   = first_kind;
        res.tag_number    = tag_counter - 32'd1;
        res.tag_type_code = current_type;
        res.length_value  = {8'd0, current_size};
        res.time_stamp    = current_time;
        if (first_kind == KIND_AUDIO) begin
          res.sound_format = data_byte[7:4];
          res.rate_code    = data_byte[3:2];
          res.sample_wide  = data_byte[1];
          res.is_stereo    = data_byte[0];
        end else begin
          res.frame_kind = data_byte[7:4];
          res.codec_id   = data_byte[3:0];
        end
        byte_pos_next = {8'd0, size_left};
        phase_next    = (size_left == 24'd0) ? PH_PREV_SIZE : PH_SKIP_DATA;
      end

      default: begin
        // Previous tag size: four ignored bytes.
        if (count_inc >= 32'd4) begin
          byte_pos_next = 32'd0;
          phase_next    = PH_TAG_HEADER;
        end else begin
          byte_pos_next = count_inc;
          phase_next    = PH_PREV_SIZE;
        end
      end
    endcase
  end

  // State registers advance only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      byte_pos          <= 32'd0;
      assembly_word     <= 32'd0;
      tag_counter       <= 32'd0;
      current_type      <= 8'd0;
      current_size      <= 24'd0;
      current_time      <= 24'd0;
      header_flags_held <= 8'd0;
    end else if (fire) begin
      phase             <= phase_next;
      byte_pos          <= byte_pos_next;
      assembly_word     <= assembly_word_next;
      tag_counter       <= tag_counter_next;
      current_type      <= current_type_next;
      current_size      <= current_size_next;
      current_time      <= current_time_next;
      header_flags_held <= header_flags_held_next;
    end
  end

  // The first data phase always holds a pending audio or video kind.
  a_first_kind: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FIRST_DATA |->
      (assembly_word == 32'd1 || assembly_word == 32'd2) && current_size != 24'd0)
    else $error("first data phase without a pending media tag");

  // The previous-size phase never counts past its four bytes.
  a_prev_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PREV_SIZE |-> byte_pos < 32'd4)
    else $error("previous size count out of range");

  // A skip phase always has bytes left to skip.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP_OFFSET || phase == PH_SKIP_DATA) |-> byte_pos != 32'd0)
    else $error("skip phase with zero bytes left");

endmodule

// ----- hw/rtl/flv_tag_stream_parser_top.sv -----
// A record word is offered on the master side from the output register, or parked in the
// skid register during an output stall. Throughput: one byte accepted per cycle while the
// skid register is empty; the parser state updates in a single registered pass, and an
// output register plus one skid register absorb downstream stalls so s_tready depends
// only on local state. Reset (rst, synchronous, active high) returns to the file header
// phase, clears counters, the mode register and the valid flags of both output registers.
// Top level of the FLV tag stream parser; depends on flvp_pkg and flvp_core.
module flv_tag_stream_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: separate_av.
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  // Input stream; tdata: data_byte[7:0].
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [flvp_pkg::IN_DATA_W-1:0]  s_tdata,
  // Output stream; tdata from bit 0: tag_number[31:0], tag_type_code[39:32],
  // length_value[71:40], time_stamp[95:72], file_flags[103:96],
  // sound_format[107:104], rate_code[109:108], sample_wide[110], is_stereo[111],
  // frame_kind[115:112], codec_id[119:116].
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [flvp_pkg::OUT_DATA_W-1:0] m_tdata,
  // tuser: record_kind[1:0].
  output logic [flvp_pkg::OUT_USER_W-1:0] m_tuser
);
  import flvp_pkg::*;

  logic    separate_av;
  logic    fire;
  logic    res_valid;
  record_t res;
  record_t out_rec;
  record_t skid_rec;
  logic    skid_valid;
  logic    out_free;

  assign s_tready = !skid_valid;
  assign fire     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      separate_av <= 1'b0;
    end else if (cfg_we) begin
      separate_av <= cfg_wdata;
    end
  end

  flvp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .data_byte   (s_tdata),
    .separate_av (separate_av),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= fire && res_valid;
      end
    end else if (fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_rec <= skid_valid ? skid_rec : res;
    end else if (fire && res_valid) begin
      skid_rec <= res;
    end
  end

  // Pack the record onto the stream.
  assign m_tuser = out_rec.record_kind;
  assign m_tdata = {out_rec.codec_id, out_rec.frame_kind, out_rec.is_stereo,
                    out_rec.sample_wide, out_rec.rate_code, out_rec.sound_format,
                    out_rec.file_flags, out_rec.time_stamp, out_rec.length_value,
                    out_rec.tag_type_code, out_rec.tag_number};

  // A parked word always sits behind a word on the output.
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held while output empty");

  // A new record during a stall goes into the skid entry.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && fire && res_valid) |=> skid_valid)
    else $error("record lost during output stall");

  // The skid entry drains only when the output moves.
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> skid_valid)
    else $error("skid entry dropped without a transfer");

endmodule

// ----- tb/sv/flv_record_checker.sv -----
`timescale 1ns / 100ps
// Checker for the FLV tag stream parser: watches the byte and record streams,
// runs its own parse of the byte stream and compares every record word it sees.
// Depends on flvp_pkg for the record type and the kind and tag type codes.
module flv_record_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [flvp_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [flvp_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [flvp_pkg::OUT_USER_W-1:0] m_tuser,
  output int                              fail_count,
  output int                              pending
);
  import flvp_pkg::*;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_SKIP_OFFSET,
    ST_PREV_SIZE,
    ST_TAG_HEADER,
    ST_FIRST_DATA,
    ST_SKIP_DATA
  } parse_state_e;

  // Shadow copy of the parser state and the mode register.
  parse_state_e st;
  logic         separate_av;
  logic [31:0]  byte_idx;
  logic [31:0]  shift_word;
  logic [31:0]  tag_count;
  logic [7:0]   cur_type;
  logic [23:0]  tag_size;
  logic [23:0]  tag_stamp;
  logic [7:0]   flags_held;
  logic [1:0]   first_kind;

  record_t records_due[$];

  // Enter the skip of the tag data, or go straight to the next previous size.
  task automatic skip_data(input logic [31:0] count);
    byte_idx = count;
    st = (count == 0) ? ST_PREV_SIZE : ST_SKIP_DATA;
  endtask

  // Queue a tag record; the first data byte is decoded only when one was read.
  task automatic queue_tag(input logic [1:0] kind, input logic [31:0] number,
                           input logic [7:0] first, input logic decode);
    record_t rec;
    rec = '0;
    rec.record_kind   = kind;
    rec.tag_number    = number;
    rec.tag_type_code = cur_type;
    rec.length_value  = {8'd0, tag_size};
    rec.time_stamp    = tag_stamp;
    if (decode && kind == KIND_AUDIO) begin
      rec.sound_format = first[7:4];
      rec.rate_code    = first[3:2];
      rec.sample_wide  = first[1];
      rec.is_stereo    = first[0];
    end else if (decode && kind == KIND_VIDEO) begin
      rec.frame_kind = first[7:4];
      rec.codec_id   = first[3:0];
    end
    records_due.push_back(rec);
  endtask

  // Advance the shadow parser by one accepted byte.
  task automatic parse_byte(input logic [7:0] b);
    record_t     rec;
    logic [31:0] idx;
    logic [7:0]  eff_type;
    logic [1:0]  kind;
    logic        emits;
    logic [31:0] number;
    idx = byte_idx;
    case (st)
      ST_HEADER: begin
        if (idx == 4) flags_held = b;
        if (idx >= 5) shift_word = {shift_word[23:0], b};
        byte_idx = idx + 1;
        if (idx >= 8) begin
          rec = '0;
          rec.record_kind  = KIND_HEADER;
          rec.length_value = shift_word;
          rec.file_flags   = flags_held;
          records_due.push_back(rec);
          // An offset of 9 or less means the first tag follows at once.
          if (shift_word > 9) begin
            byte_idx = shift_word - 9;
            st = ST_SKIP_OFFSET;
          end else begin
            byte_idx = 0;
            st = ST_PREV_SIZE;
          end
        end
      end
      ST_SKIP_OFFSET, ST_SKIP_DATA: begin
        if (byte_idx > 0) byte_idx = byte_idx - 1;
        if (byte_idx == 0) st = ST_PREV_SIZE;
      end
      ST_TAG_HEADER: begin
        byte_idx = idx + 1;
        if (idx == 0) begin
          cur_type = b;
        end else if (idx <= 3) begin
          shift_word = (idx == 1) ? {24'd0, b} : {shift_word[23:0], b};
          if (idx == 3) tag_size = shift_word[23:0];
        end else if (idx <= 6) begin
          shift_word = (idx == 4) ? {24'd0, b} : {shift_word[23:0], b};
          if (idx == 6) tag_stamp = shift_word[23:0];
        end
        // Last header byte: classify with the mode as it stands now.
        if (idx >= 10) begin
          eff_type = separate_av ? cur_type : VIDEO_TAG;
          emits = 1'b1;
          kind  = KIND_HEADER;
          if (eff_type == AUDIO_TAG) kind = KIND_AUDIO;
          else if (eff_type == VIDEO_TAG) kind = KIND_VIDEO;
          else if (eff_type == SCRIPT_TAG) kind = KIND_SCRIPT;
          else emits = 1'b0;
          number = tag_count;
          tag_count = tag_count + 1;
          if ((kind == KIND_AUDIO || kind == KIND_VIDEO) && tag_size != 0) begin
            first_kind = kind;
            byte_idx = 0;
            st = ST_FIRST_DATA;
          end else begin
            skip_data({8'd0, tag_size});
            if (emits) queue_tag(kind, number, 8'd0, 1'b0);
          end
        end
      end
      ST_FIRST_DATA: begin
        queue_tag(first_kind, tag_count - 1, b, 1'b1);
        skip_data({8'd0, tag_size} - 1);
      end
      default: begin
        // Previous tag size: four bytes that carry nothing.
        byte_idx = idx + 1;
        if (byte_idx >= 4) begin
          byte_idx = 0;
          st = ST_TAG_HEADER;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare one record word with the oldest expected record.
  task automatic check_record();
    record_t want;
    if (records_due.size() == 0) begin
      $error("record word with no record expected, kind %0d", m_tuser);
      fail_count++;
    end else begin
      want = records_due.pop_front();
      check_field("record_kind",   32'(want.record_kind),   32'(m_tuser[1:0]));
      check_field("tag_number",    want.tag_number,         m_tdata[31:0]);
      check_field("tag_type_code", 32'(want.tag_type_code), 32'(m_tdata[39:32]));
      check_field("length_value",  want.length_value,       m_tdata[71:40]);
      check_field("time_stamp",    32'(want.time_stamp),    32'(m_tdata[95:72]));
      check_field("file_flags",    32'(want.file_flags),    32'(m_tdata[103:96]));
      check_field("sound_format",  32'(want.sound_format),  32'(m_tdata[107:104]));
      check_field("rate_code",     32'(want.rate_code),     32'(m_tdata[109:108]));
      check_field("sample_wide",   32'(want.sample_wide),   32'(m_tdata[110]));
      check_field("is_stereo",     32'(want.is_stereo),     32'(m_tdata[111]));
      check_field("frame_kind",    32'(want.frame_kind),    32'(m_tdata[115:112]));
      check_field("codec_id",      32'(want.codec_id),      32'(m_tdata[119:116]));
    end
  endtask

  // Outputs are checked before the byte of the same edge is parsed, since a
  // record never leaves in the cycle its last byte arrives.
  always @(posedge clk) begin
    if (rst) begin
      st          = ST_HEADER;
      separate_av = 1'b0;
      byte_idx    = '0;
      shift_word  = '0;
      tag_count   = '0;
      cur_type    = '0;
      tag_size    = '0;
      tag_stamp   = '0;
      flags_held  = '0;
      first_kind  = KIND_HEADER;
      records_due.delete();
    end else begin
      if (m_tvalid && m_tready) check_record();
      if (s_tvalid && s_tready) parse_byte(s_tdata);
      if (cfg_we) separate_av = cfg_wdata;
    end
    pending = records_due.size();
  end

endmodule

// ----- tb/sv/flv_tag_stream_parser_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the FLV tag stream parser: builds FLV byte streams, drives
// the byte and record handshakes and gives the verdict.
// Depends on flvp_pkg, flv_tag_stream_parser_top and flv_record_checker.
module flv_tag_stream_parser_top_tb;
  import flvp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int BYTE_TARGET = 1700;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic                  cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  int fail_count;
  int pending;
  int byte_total;
  int quiet_cycles;
  int hold_reqs;
  int holds_done;
  int hold_left;
  bit steady;

  flv_tag_stream_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  flv_record_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Record sink: random stalls, steady stretches, and long hold-offs on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (holds_done != hold_reqs) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  // Watchdog: ends the run when neither stream moves for too long.
  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[flv_tag_stream_parser_top] ERROR");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until the parser takes the word.
  task automatic push_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    byte_total++;
    @(negedge clk);
  endtask

  // File header with a big-endian data offset, then the bytes up to it.
  task automatic push_header(input logic [31:0] offset);
    repeat (4) push_byte(8'($urandom_range(255)));
    push_byte(8'($urandom_range(255)));
    push_byte(offset[31:24]);
    push_byte(offset[23:16]);
    push_byte(offset[15:8]);
    push_byte(offset[7:0]);
    if (offset > 9) repeat (offset - 9) push_byte(8'($urandom_range(255)));
  endtask

  // Previous size, tag header and tag data; the stream id is random noise.
  task automatic push_tag(input logic [7:0] type_byte, input logic [23:0] size,
                          input logic [23:0] stamp, input logic [7:0] first);
    repeat (4) push_byte(8'($urandom_range(255)));
    push_byte(type_byte);
    push_byte(size[23:16]);
    push_byte(size[15:8]);
    push_byte(size[7:0]);
    push_byte(stamp[23:16]);
    push_byte(stamp[15:8]);
    push_byte(stamp[7:0]);
    repeat (4) push_byte(8'($urandom_range(255)));
    if (size != 0) begin
      push_byte(first);
      repeat (size - 1) push_byte(8'($urandom_range(255)));
    end
  endtask

  // Mostly audio, video and script tags with small sizes, some other types.
  task automatic push_random_tag();
    logic [7:0]  type_byte;
    logic [23:0] size;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 35) type_byte = AUDIO_TAG;
    else if (pick < 70) type_byte = VIDEO_TAG;
    else if (pick < 85) type_byte = SCRIPT_TAG;
    else type_byte = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 25) size = 24'd0;
    else if (pick < 85) size = 24'($urandom_range(1, 6));
    else if (pick < 97) size = 24'($urandom_range(7, 64));
    else size = 24'($urandom_range(200, 300));
    push_tag(type_byte, size, 24'($urandom), 8'($urandom_range(255)));
  endtask

  // Let the parser drain, then write the mode register while nothing moves.
  task automatic set_mode(input logic mode);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int phase;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: everything treated as video first.
    set_mode(1'b0);
    push_header($urandom_range(1) ? $urandom_range(0, 9) : $urandom_range(10, 40));
    push_tag(AUDIO_TAG, 24'd1, 24'h000000, 8'h00);
    push_tag(SCRIPT_TAG, 24'd2, 24'hffffff, 8'hff);
    push_tag(8'h00, 24'd0, 24'h123456, 8'h00);
    push_tag(8'hff, 24'd3, 24'h654321, 8'ha5);

    // Directed part: tags classified by type.
    set_mode(1'b1);
    push_tag(AUDIO_TAG, 24'd1, 24'h000001, 8'hff);
    push_tag(AUDIO_TAG, 24'd4, 24'h800000, 8'h00);
    push_tag(AUDIO_TAG, 24'd0, 24'h00ff00, 8'h00);
    push_tag(VIDEO_TAG, 24'd2, 24'hffffff, 8'hff);
    push_tag(VIDEO_TAG, 24'd1, 24'h000000, 8'h00);
    push_tag(VIDEO_TAG, 24'd0, 24'h0000ff, 8'h00);
    push_tag(SCRIPT_TAG, 24'd3, 24'h7fffff, 8'h3c);
    push_tag(SCRIPT_TAG, 24'd0, 24'h000010, 8'h00);
    push_tag(8'h00, 24'd2, 24'h000020, 8'h5a);
    push_tag(8'hff, 24'd0, 24'h000030, 8'h00);
    push_tag(8'h07, 24'd1, 24'h000040, 8'hc3);
    push_tag(AUDIO_TAG, 24'd300, 24'hfedcba, 8'h5a);

    // Random phases; the second one stalls the sink long enough to back up
    // the parser, the third runs both sides without gaps.
    phase = 0;
    while (byte_total < BYTE_TARGET || phase < 3) begin
      set_mode((phase == 1) ? 1'b0 : 1'($urandom_range(1)));
      steady = (phase == 2);
      if (phase == 1) begin
        hold_reqs++;
        repeat (12) push_tag(8'($urandom_range(255)), 24'd0, 24'($urandom), 8'h00);
      end else begin
        repeat ($urandom_range(8, 16)) begin
          if (byte_total < BYTE_TARGET) push_random_tag();
        end
      end
      phase++;
    end
    steady = 1'b0;

    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[flv_tag_stream_parser_top] OK");
    end else begin
      $display("[flv_tag_stream_parser_top] ERROR");
    end
    $finish;
  end

endmodule
